[hdl/aabb_transform_frustum_cull_macros.svh]
// Assertion macros for the frustum cull block.
`ifndef AABB_TRANSFORM_FRUSTUM_CULL_MACROS_SVH
`define AABB_TRANSFORM_FRUSTUM_CULL_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define AFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hdl/afc_pkg.sv]
// Shared types and constants for the frustum cull block.
package afc_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = COORD_BITS / 2;
    localparam int NUM_PLANES = 6;
    localparam int FIELD_BITS = 48;
    localparam int PLANE_BITS = 64;
    localparam int IDX_BITS   = 3;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    // world coordinate: translation<<F plus three products, 2F fraction bits
    localparam int WORLD_BITS = PROD_BITS + 3;
    // distance: n*world + d<<(2F), sum of four terms
    localparam int DIST_BITS  = COORD_BITS + WORLD_BITS + 3;
    localparam int NUM_STAGES = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WORLD_BITS-1:0] world_t;
    typedef logic signed [DIST_BITS-1:0]  dist_t;

    // Element k of a packed word; positions beyond the word read zero.
    function automatic coord_t elem48(input logic [FIELD_BITS-1:0] w, input int k);
        logic [FIELD_BITS+COORD_BITS-1:0] ext;
        ext = {{COORD_BITS{1'b0}}, w};
        if (k * COORD_BITS >= FIELD_BITS)
            return '0;
        return coord_t'(ext[k*COORD_BITS +: COORD_BITS]);
    endfunction

    function automatic coord_t elem64(input logic [PLANE_BITS-1:0] w, input int k);
        logic [PLANE_BITS+COORD_BITS-1:0] ext;
        ext = {{COORD_BITS{1'b0}}, w};
        if (k * COORD_BITS >= PLANE_BITS)
            return '0;
        return coord_t'(ext[k*COORD_BITS +: COORD_BITS]);
    endfunction
endpackage

[hdl/afc_if.sv]
// Valid/ready channel interfaces for box items and cull results.
interface afc_box_if;
    logic                          valid;
    logic                          ready;
    logic [afc_pkg::FIELD_BITS-1:0] box_low;
    logic [afc_pkg::FIELD_BITS-1:0] box_high;
    logic [afc_pkg::FIELD_BITS-1:0] matrix_row_0;
    logic [afc_pkg::FIELD_BITS-1:0] matrix_row_1;
    logic [afc_pkg::FIELD_BITS-1:0] matrix_row_2;
    logic [afc_pkg::FIELD_BITS-1:0] translation;
    modport source (output valid, box_low, box_high, matrix_row_0, matrix_row_1,
                    matrix_row_2, translation, input ready);
    modport sink (input valid, box_low, box_high, matrix_row_0, matrix_row_1,
                  matrix_row_2, translation, output ready);
endinterface

interface afc_res_if;
    logic valid;
    logic ready;
    logic culled;
    modport source (output valid, culled, input ready);
    modport sink (input valid, culled, output ready);
endinterface

[hdl/afc_plane_test.sv]
// One plane test: corner select and three products registered, then a combinational sign check.
module afc_plane_test (
    input  logic                           clk,
    input  logic                           en,
    input  logic [afc_pkg::PLANE_BITS-1:0] plane,
    input  afc_pkg::world_t                wmin [3],
    input  afc_pkg::world_t                wmax [3],
    output logic                           behind
);
    import afc_pkg::*;

    localparam int TERM_BITS = COORD_BITS + WORLD_BITS;

    logic signed [TERM_BITS-1:0] term_reg [3];
    dist_t                       off_reg;
    dist_t                       sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (elem64(plane, i) < 0)
                    term_reg[i] <= elem64(plane, i) * wmin[i];
                else
                    term_reg[i] <= elem64(plane, i) * wmax[i];
            end
            // d has F fraction bits, n*corner has 3F
            off_reg <= dist_t'(elem64(plane, 3)) <<< (2 * FRAC_BITS);
        end
    end

    assign sum = off_reg + dist_t'(term_reg[0]) + dist_t'(term_reg[1])
                 + dist_t'(term_reg[2]);
    assign behind = sum[DIST_BITS-1];
endmodule

[hdl/aabb_transform_frustum_cull.sv]
// Top level: box transform and frustum cull pipeline.
//  channel | dir | payload
//  box     | in  | box_low, box_high, matrix_row_0..2, translation
//  res     | out | culled
//  cfg     | in  | cfg_we, cfg_index, cfg_data (plane_0..plane_5)
// One item per cycle while the output register is not stalled.
// Stages: products, world min/max sums, plane products, sign and OR.
// The whole pipeline advances only when the output register is free or taken.
// Reset clears valid bits and planes; a stall holds every stage.
module aabb_transform_frustum_cull (
    input  logic                             clk,
    input  logic                             rst_n,
    afc_box_if.sink                          box,
    afc_res_if.source                        res,
    input  logic                             cfg_we,
    input  logic [afc_pkg::IDX_BITS-1:0]     cfg_index,
    input  logic [afc_pkg::PLANE_BITS-1:0]   cfg_data
);
    import afc_pkg::*;

    logic [PLANE_BITS-1:0] plane_reg [NUM_PLANES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic                  adv;

    logic signed [PROD_BITS-1:0] e_reg [3][3];
    logic signed [PROD_BITS-1:0] f_reg [3][3];
    coord_t                      t_reg [3];
    world_t                      wmin_reg [3];
    world_t                      wmax_reg [3];
    logic [NUM_PLANES-1:0]       behind;
    logic                        culled_reg;

    assign adv      = !valid_reg[NUM_STAGES-1] || res.ready;
    assign box.ready = adv;
    assign res.valid = valid_reg[NUM_STAGES-1];
    assign res.culled = culled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
                plane_reg[p] <= '0;
        end
        else if (cfg_we && cfg_index < IDX_BITS'(NUM_PLANES))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NUM_STAGES-2:0], box.valid};
    end

    // stage 1: min/max product candidates, row j column i
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i] <= elem48(box.translation, i);
                for (int j = 0; j < 3; j++)
                begin
                    logic [FIELD_BITS-1:0] row;
                    row = (j == 0) ? box.matrix_row_0 :
                          (j == 1) ? box.matrix_row_1 : box.matrix_row_2;
                    e_reg[j][i] <= elem48(row, i) * elem48(box.box_low, j);
                    f_reg[j][i] <= elem48(row, i) * elem48(box.box_high, j);
                end
            end
        end
    end

    // stage 2: world bounds
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                world_t mn;
                world_t mx;
                mn = world_t'(t_reg[i]) <<< FRAC_BITS;
                mx = mn;
                for (int j = 0; j < 3; j++)
                begin
                    if (e_reg[j][i] < f_reg[j][i])
                    begin
                        mn = mn + world_t'(e_reg[j][i]);
                        mx = mx + world_t'(f_reg[j][i]);
                    end
                    else
                    begin
                        mn = mn + world_t'(f_reg[j][i]);
                        mx = mx + world_t'(e_reg[j][i]);
                    end
                end
                wmin_reg[i] <= mn;
                wmax_reg[i] <= mx;
            end
        end
    end

    // stage 3 inside plane units; stage 4 output
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        afc_plane_test u_test (
            .clk    (clk),
            .en     (adv),
            .plane  (plane_reg[p]),
            .wmin   (wmin_reg),
            .wmax   (wmax_reg),
            .behind (behind[p])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            culled_reg <= |behind;
    end
endmodule

[hdl/afc_checker.sv]
// Port-level checker for the frustum cull block, bound to the top level.
`include "aabb_transform_frustum_cull_macros.svh"
module afc_checker (
    input logic clk,
    input logic rst_n,
    input logic box_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_culled
);
    `AFC_ASSERT_NXT(a_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_culled))
    `AFC_ASSERT_IMP(a_ready, clk, rst_n, !res_valid, box_ready)
    `AFC_ASSERT_IMP(a_stall, clk, rst_n, res_valid && !res_ready, !box_ready)
endmodule

bind aabb_transform_frustum_cull afc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .box_ready  (box.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_culled (res.culled)
);
